// ===== sv/dstq_pkg.sv =====
// Shared types and codes for the deadline sorted timer queue.
// Used by dstq_front, dstq_back and the top level; depends on nothing.
package dstq_pkg;

  localparam int ID_W   = 4;
  localparam int PER_W  = 32;
  localparam int CNT_W  = 16;
  localparam int TIME_W = 48;
  localparam int QUE_W  = 5;

  typedef enum logic [1:0] {
    OP_REG   = 2'd0,
    OP_UNREG = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_REGISTERED = 3'd0,
    K_REJECTED   = 3'd1,
    K_UNREGD     = 3'd2,
    K_FIRED      = 3'd3,
    K_NONE_DUE   = 3'd4
  } kind_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [PER_W-1:0]  period;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  fire_time;
    logic [QUE_W-1:0]   queued;
    logic               last;
  } res_t;

endpackage

// ===== sv/dstq_front.sv =====
// Front end: accepts command transactions, classifies them and buffers them
// in a two-entry queue for the back end. Depends on dstq_pkg.
module dstq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dstq_pkg::cmd_t      in_cmd,
  output logic                cmd_valid,
  input  logic                cmd_pop,
  output dstq_pkg::cmd_t      cmd_out
);

  dstq_pkg::cmd_t fifo_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     fill_r;
  logic           push;
  logic           pop;

  assign in_ready  = (fill_r != 2'd2);
  // unused command code produces nothing, so it is dropped here
  assign push      = in_valid && in_ready && (in_cmd.op != dstq_pkg::OP_NONE);
  assign cmd_valid = (fill_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_out   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + 2'(push) - 2'(pop);
    end
  end

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 2'd2)
    else $error("front queue overfilled");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == 2'd2 |-> !push)
    else $error("push into full front queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> fill_r != 2'd0)
    else $error("pop from empty front queue");

endmodule

// ===== sv/dstq_back.sv =====
// Back end: sorted deadline queue, timer tables and the sequencer that runs
// register, unregister and tick commands; holds the result register. Uses dstq_pkg.
module dstq_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIMER_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  dstq_pkg::cmd_t     cmd_in,
  output logic               out_valid,
  input  logic               out_ready,
  output dstq_pkg::res_t     out_res
);

  localparam int IW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TIW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int TW  = dstq_pkg::TIME_W;
  localparam int DW  = dstq_pkg::ID_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INS   = 6'b000010,
    S_UNREG = 6'b000100,
    S_CHK   = 6'b001000,
    S_POP   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  logic [DW-1:0]                q_id    [QUEUE_DEPTH];
  logic [TW-1:0]                q_dl    [QUEUE_DEPTH];
  logic [dstq_pkg::PER_W-1:0]   per_tab [TIMER_COUNT];
  logic [dstq_pkg::CNT_W-1:0]   rem_tab [TIMER_COUNT];

  state_t          state_r, ret_r;
  logic [CW-1:0]   count_r;
  logic [TW-1:0]   now_r;
  logic [CW-1:0]   ptr_r;    // insert walk / pop index / unregister read
  logic [CW-1:0]   wptr_r;   // unregister write
  logic [DW-1:0]   ins_id_r;
  logic [TW-1:0]   ins_dl_r;
  logic            after_fire_r;
  logic [DW-1:0]   fid_r;
  logic [TW-1:0]   fdl_r;
  logic            have_pend_r;
  dstq_pkg::res_t  pend_r, res_r, out_res_r;
  logic            out_valid_r;

  logic [IW-1:0]                 pi, pim1, wi;
  logic [TIW-1:0]                ti_cmd, ti_fid;
  logic                          due, out_free, fid_ok, requeue, load_out;
  logic [dstq_pkg::CNT_W-1:0]    rem;
  logic [dstq_pkg::PER_W-1:0]    per;

  assign pi       = ptr_r[IW-1:0];
  assign pim1     = IW'(ptr_r - CW'(1));
  assign wi       = wptr_r[IW-1:0];
  assign ti_cmd   = TIW'(cmd_in.id);
  assign ti_fid   = TIW'(fid_r);
  assign due      = (count_r != '0) && (q_dl[0] <= now_r);
  assign out_free = !out_valid_r || out_ready;
  assign load_out = (state_r == S_OUT) && out_free;
  assign fid_ok   = (32'(fid_r) < TIMER_COUNT);
  assign rem      = rem_tab[ti_fid];
  assign per      = per_tab[ti_fid];
  assign requeue  = fid_ok && ((rem == '0) || (rem > 16'd1));
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      count_r      <= '0;
      now_r        <= '0;
      have_pend_r  <= 1'b0;
      ptr_r        <= '0;
      wptr_r       <= '0;
      after_fire_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd_in.op)
              dstq_pkg::OP_REG: begin
                if ((32'(cmd_in.id) >= TIMER_COUNT) || (32'(count_r) >= QUEUE_DEPTH)) begin
                  res_r   <= '{dstq_pkg::K_REJECTED, cmd_in.id, '0,
                               dstq_pkg::QUE_W'(count_r), 1'b1};
                  ret_r   <= S_IDLE;
                  state_r <= S_OUT;
                end else begin
                  per_tab[ti_cmd] <= cmd_in.period;
                  rem_tab[ti_cmd] <= cmd_in.count;
                  ins_id_r     <= cmd_in.id;
                  ins_dl_r     <= now_r + TW'(cmd_in.period);
                  ptr_r        <= count_r;
                  after_fire_r <= 1'b0;
                  state_r      <= S_INS;
                end
              end
              dstq_pkg::OP_UNREG: begin
                ins_id_r <= cmd_in.id;
                ptr_r    <= '0;
                wptr_r   <= '0;
                state_r  <= S_UNREG;
              end
              dstq_pkg::OP_TICK: begin
                now_r       <= now_r + TW'(1);
                have_pend_r <= 1'b0;
                state_r     <= S_CHK;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_INS: begin
          // walk from the tail, shifting entries whose deadline is not below the new one
          if ((ptr_r != '0) && !(q_dl[pim1] < ins_dl_r)) begin
            q_id[pi] <= q_id[pim1];
            q_dl[pi] <= q_dl[pim1];
            ptr_r    <= ptr_r - CW'(1);
          end else begin
            q_id[pi] <= ins_id_r;
            q_dl[pi] <= ins_dl_r;
            count_r  <= count_r + CW'(1);
            if (after_fire_r) begin
              pend_r      <= '{dstq_pkg::K_FIRED, fid_r, fdl_r,
                               dstq_pkg::QUE_W'(count_r + CW'(1)), 1'b0};
              have_pend_r <= 1'b1;
              state_r     <= S_CHK;
            end else begin
              res_r   <= '{dstq_pkg::K_REGISTERED, ins_id_r, ins_dl_r,
                           dstq_pkg::QUE_W'(count_r + CW'(1)), 1'b1};
              ret_r   <= S_IDLE;
              state_r <= S_OUT;
            end
          end
        end
        S_UNREG: begin
          if (ptr_r < count_r) begin
            if (q_id[pi] != ins_id_r) begin
              q_id[wi] <= q_id[pi];
              q_dl[wi] <= q_dl[pi];
              wptr_r   <= wptr_r + CW'(1);
            end
            ptr_r <= ptr_r + CW'(1);
          end else begin
            count_r <= wptr_r;
            res_r   <= '{dstq_pkg::K_UNREGD, ins_id_r, '0,
                         dstq_pkg::QUE_W'(wptr_r), 1'b1};
            ret_r   <= S_IDLE;
            state_r <= S_OUT;
          end
        end
        S_CHK: begin
          if (due) begin
            if (have_pend_r) begin
              res_r       <= pend_r;
              have_pend_r <= 1'b0;
              ret_r       <= S_CHK;
              state_r     <= S_OUT;
            end else begin
              fid_r   <= q_id[0];
              fdl_r   <= q_dl[0];
              ptr_r   <= CW'(1);
              state_r <= S_POP;
            end
          end else begin
            if (have_pend_r) begin
              res_r <= '{pend_r.kind, pend_r.id, pend_r.fire_time, pend_r.queued, 1'b1};
            end else begin
              res_r <= '{dstq_pkg::K_NONE_DUE, '0, now_r,
                         dstq_pkg::QUE_W'(count_r), 1'b1};
            end
            have_pend_r <= 1'b0;
            ret_r       <= S_IDLE;
            state_r     <= S_OUT;
          end
        end
        S_POP: begin
          if (ptr_r < count_r) begin
            q_id[pim1] <= q_id[pi];
            q_dl[pim1] <= q_dl[pi];
            ptr_r      <= ptr_r + CW'(1);
          end else begin
            count_r <= count_r - CW'(1);
            if (requeue) begin
              if (rem > 16'd1) rem_tab[ti_fid] <= rem - 16'd1;
              ins_id_r     <= fid_r;
              ins_dl_r     <= now_r + TW'((per == '0) ? 32'd1 : per);
              ptr_r        <= count_r - CW'(1);
              after_fire_r <= 1'b1;
              state_r      <= S_INS;
            end else begin
              pend_r      <= '{dstq_pkg::K_FIRED, fid_r, fdl_r,
                               dstq_pkg::QUE_W'(count_r - CW'(1)), 1'b0};
              have_pend_r <= 1'b1;
              state_r     <= S_CHK;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_res_r <= res_r;
            state_r   <= ret_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= QUEUE_DEPTH)
    else $error("queue count beyond depth");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !have_pend_r)
    else $error("fired result left pending at idle");
  a_none_due_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind == dstq_pkg::K_NONE_DUE |-> out_res_r.last)
    else $error("empty tick result without last");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> count_r != '0)
    else $error("pop from empty queue");

endmodule

// ===== sv/deadline_sorted_timer_queue.sv =====
// Top level of the deadline sorted timer queue.
// Instantiates dstq_front and dstq_back; uses dstq_pkg.
//
// Usage: commands arrive on the in_ stream (register, unregister, 1 ms tick)
// with the command code on in_tuser, and results leave on the out_ stream with
// the result kind on out_tuser, one or more per command, the final one flagged
// by out_tlast. Command code 3 is swallowed without a result.
// Register inserts by a walk over the queue from the tail, unregister makes a
// compaction pass, and a tick pops the head of each due entry and re-inserts
// it unless its execution count is used up; each of these walks the
// single-port queue array.
// A two-entry command queue lets commands be taken while the back end is
// busy or a result is held; a held result stalls the sequencer only when the
// next result is ready, and in_tready drops once the command queue is full.
// Reset empties the queue and sets the millisecond time to zero; the timer
// tables and queue contents are undefined until written.
module deadline_sorted_timer_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIMER_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // timer_id[3:0], period_ms[35:4], execution_count[51:36]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // fired_id[3:0], fire_time[51:4], queued[56:52]
  output logic [2:0]  out_tuser,  // kind[2:0]
  output logic        out_tlast
);

  dstq_pkg::cmd_t in_cmd, cmd;
  dstq_pkg::res_t res;
  logic           cmd_valid, cmd_pop;

  assign in_cmd = '{dstq_pkg::op_t'(in_tuser), in_tdata[3:0],
                    in_tdata[35:4], in_tdata[51:36]};

  dstq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_out   (cmd)
  );

  dstq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIMER_COUNT (TIMER_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_in    (cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {7'b0, res.queued, res.fire_time, res.id};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ===== dv/deadline_sorted_timer_queue_tb.sv =====
// Testbench for deadline_sorted_timer_queue: drives register, unregister and
// tick transactions and checks every result against an in-house predictor.
// Depends on dstq_pkg and the deadline_sorted_timer_queue RTL.
module deadline_sorted_timer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int NTIMERS = 16;
  localparam longint LIMIT = 1500000;

  typedef struct {
    dstq_pkg::kind_t kind;
    logic [3:0] id;
    logic [47:0] t;
    logic [4:0] queued;
    logic last;
  } firing_t;

  class timer_scoreboard;
    logic [3:0] q_id[DEPTH];
    logic [47:0] q_dl[DEPTH];
    int n_queued;
    logic [47:0] now_ms;
    logic [31:0] periods[NTIMERS];
    logic [15:0] remaining[NTIMERS];
    firing_t pending[$];
    int errors;

    function new();
      n_queued = 0;
      now_ms = '0;
      errors = 0;
    endfunction

    function void insert(logic [3:0] id, logic [47:0] dl);
      int pos;
      pos = 0;
      while (pos < n_queued && q_dl[pos] < dl) pos++;
      for (int i = n_queued; i > pos; i--) begin
        q_id[i] = q_id[i-1];
        q_dl[i] = q_dl[i-1];
      end
      q_id[pos] = id;
      q_dl[pos] = dl;
      n_queued++;
    endfunction

    function void push(dstq_pkg::kind_t k, logic [3:0] id, logic [47:0] t, logic last);
      firing_t f;
      f.kind = k;
      f.id = id;
      f.t = t;
      f.queued = n_queued[4:0];
      f.last = last;
      pending.push_back(f);
    endfunction

    function void note_command(dstq_pkg::op_t op, logic [3:0] id, logic [31:0] per,
                               logic [15:0] cnt);
      int w, fired;
      logic [3:0] fid;
      logic [47:0] fdl;
      logic [15:0] rem;
      case (op)
        dstq_pkg::OP_REG: begin
          if (n_queued >= DEPTH) begin
            push(dstq_pkg::K_REJECTED, id, '0, 1'b1);
          end else begin
            periods[id] = per;
            remaining[id] = cnt;
            insert(id, now_ms + 48'(per));
            push(dstq_pkg::K_REGISTERED, id, now_ms + 48'(per), 1'b1);
          end
        end
        dstq_pkg::OP_UNREG: begin
          w = 0;
          for (int r = 0; r < n_queued; r++) begin
            if (q_id[r] != id) begin
              q_id[w] = q_id[r];
              q_dl[w] = q_dl[r];
              w++;
            end
          end
          n_queued = w;
          push(dstq_pkg::K_UNREGD, id, '0, 1'b1);
        end
        dstq_pkg::OP_TICK: begin
          now_ms = now_ms + 48'd1;
          fired = 0;
          while (n_queued > 0 && q_dl[0] <= now_ms) begin
            fid = q_id[0];
            fdl = q_dl[0];
            for (int i = 1; i < n_queued; i++) begin
              q_id[i-1] = q_id[i];
              q_dl[i-1] = q_dl[i];
            end
            n_queued--;
            rem = remaining[fid];
            if (rem != 16'd1) begin
              insert(fid, now_ms + ((periods[fid] == 0) ? 48'd1 : 48'(periods[fid])));
              if (rem > 16'd1) remaining[fid] = rem - 16'd1;
            end
            push(dstq_pkg::K_FIRED, fid, fdl, 1'b0);
            fired++;
          end
          if (fired == 0) push(dstq_pkg::K_NONE_DUE, '0, now_ms, 1'b1);
          else pending[$].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [2:0] u, logic [63:0] d, logic tl);
      firing_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (u != e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, u); errors++;
      end
      if (d[3:0] != e.id) begin
        $error("fired_id: expected %0d actual %0d", e.id, d[3:0]); errors++;
      end
      if (d[51:4] != e.t) begin
        $error("fire_time: expected %0d actual %0d", e.t, d[51:4]); errors++;
      end
      if (d[56:52] != e.queued) begin
        $error("queued: expected %0d actual %0d", e.queued, d[56:52]); errors++;
      end
      if (tl != e.last) begin
        $error("last: expected %0d actual %0d", e.last, tl); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;

  timer_scoreboard sb;
  bit calm = 0;       // no idling in the closing stretch
  bit hold_off = 0;   // long receiver stall requested
  longint cycles = 0;

  deadline_sorted_timer_queue u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("deadline_sorted_timer_queue: mismatch");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_command(dstq_pkg::op_t'(in_tuser), in_tdata[3:0], in_tdata[35:4],
                        in_tdata[51:36]);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
    end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // valid stays up after acceptance until the next call or drain changes it
  task automatic send_cmd(dstq_pkg::op_t op, logic [3:0] id, logic [31:0] per,
                          logic [15:0] cnt);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0000, cnt, per, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'($urandom_range(0, 65535));
      2: return 16'hFFFF;
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    int r;
    sb = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: tick on empty, period extremes, duplicates, unlimited count
    send_cmd(dstq_pkg::OP_TICK, 4'd0, '0, '0);
    send_cmd(dstq_pkg::OP_REG, 4'd0, 32'd0, 16'd1);
    send_cmd(dstq_pkg::OP_REG, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(dstq_pkg::OP_REG, 4'd3, 32'd1, 16'd0);
    send_cmd(dstq_pkg::OP_REG, 4'd3, 32'd2, 16'd3);
    send_cmd(dstq_pkg::OP_REG, 4'd5, 32'd1, 16'd2);
    send_cmd(dstq_pkg::OP_NONE, 4'hF, 32'hFFFF_FFFF, 16'hFFFF);
    repeat (5) send_cmd(dstq_pkg::OP_TICK, 4'd0, '0, '0);
    send_cmd(dstq_pkg::OP_UNREG, 4'd3, '0, '0);
    send_cmd(dstq_pkg::OP_UNREG, 4'd9, '0, '0);
    send_cmd(dstq_pkg::OP_TICK, 4'hF, 32'hFFFF_FFFF, 16'hFFFF);
    // fill to full so a register is rejected, then flush
    for (int i = 0; i < 17; i++) send_cmd(dstq_pkg::OP_REG, 4'(i), 32'd1000 + i, 16'd1);
    send_cmd(dstq_pkg::OP_TICK, 4'd0, '0, '0);
    for (int i = 0; i < 16; i++) send_cmd(dstq_pkg::OP_UNREG, 4'(i), '0, '0);
    drain();
    // long receiver stall while commands keep coming
    hold_off = 1;
    for (int i = 0; i < 30; i++)
      send_cmd(($urandom_range(0, 2) == 0) ? dstq_pkg::OP_REG : dstq_pkg::OP_TICK,
               4'($urandom_range(0, 15)), $urandom_range(0, 3),
               16'($urandom_range(0, 3)));
    drain();
    for (int i = 0; i < 480; i++) begin
      if (i == 420) calm = 1;
      r = $urandom_range(0, 19);
      if (r < 8)
        send_cmd(dstq_pkg::OP_REG, 4'($urandom_range(0, 15)), pick_period(), pick_count());
      else if (r < 10)
        send_cmd(dstq_pkg::OP_UNREG, 4'($urandom_range(0, 15)), $urandom(),
                 16'($urandom()));
      else if (r < 19)
        send_cmd(dstq_pkg::OP_TICK, 4'($urandom_range(0, 15)), $urandom(),
                 16'($urandom()));
      else
        send_cmd(dstq_pkg::OP_NONE, 4'($urandom_range(0, 15)), $urandom(),
                 16'($urandom()));
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("deadline_sorted_timer_queue: match");
    else
      $display("deadline_sorted_timer_queue: mismatch");
    $finish;
  end
endmodule

// ===== deadline_sorted_timer_queue.f =====
sv/dstq_pkg.sv
sv/dstq_front.sv
sv/dstq_back.sv
sv/deadline_sorted_timer_queue.sv
dv/deadline_sorted_timer_queue_tb.sv
